// ===== sv/suffix_array_lcp_engine_assert.svh =====
// Assertion macros for the suffix array engine.
`ifndef SUFFIX_ARRAY_LCP_ENGINE_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SALCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SALCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SALCP_ASSERT(lbl, prop, msg)
`define SALCP_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/salcp_pkg.sv =====
package salcp_pkg;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_LCP  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_UNBUILT = 2'd2;

endpackage

// ===== sv/salcp_log2.sv =====
module salcp_log2 #(
    parameter int W = 11
) (
    input  logic [W-1:0]         value,
    output logic [$clog2(W)-1:0] result
);

    // floor(log2(value)); zero gives zero
    always_comb
    begin
        result = '0;
        for (int b = 0; b < W; b++)
        begin
            if (value[b])
            begin
                result = ($clog2(W))'(b);
            end
        end
    end

endmodule

// ===== sv/suffix_array_lcp_engine.sv =====
// Channel   Signals                                         Handshake
// command   cmd, char_in, last_char, pos_a, pos_b           start & !busy
// result    sa_value, rank_value, height_value, lcp_value,  done (one cycle)
//           status
//
// A load's result appears on the next cycle.
// A read passes issue and done states; an LCP query is set by the
// serial reads of the rank and sparse min memories (one read port each).
// A load with last_char set starts the build; busy stays high while
// the build walks the stores one entry at a time.
// Reset clears the text length and the built flag; memories are not cleared.
// The receiver cannot stall; results hold until the next start.
`include "suffix_array_lcp_engine_assert.svh"
module suffix_array_lcp_engine #(
    parameter int MAX_LEN    = 1024,
    parameter int LOG_LEVELS = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       cmd,
    input  logic [7:0]                       char_in,
    input  logic                             last_char,
    input  logic [$clog2(MAX_LEN+1)-1:0]     pos_a,
    input  logic [$clog2(MAX_LEN+1)-1:0]     pos_b,
    output logic                             done,
    output logic [$clog2(MAX_LEN+1)-1:0]     sa_value,
    output logic [$clog2(MAX_LEN+1)-1:0]     rank_value,
    output logic [$clog2(MAX_LEN+1)-1:0]     height_value,
    output logic [$clog2(MAX_LEN+1)-1:0]     lcp_value,
    output logic [1:0]                       status
);

    import salcp_pkg::*;

    localparam int D  = MAX_LEN + 1;
    localparam int PW = $clog2(D);
    localparam int SD = LOG_LEVELS * D;
    localparam int SW = $clog2(SD);
    localparam int LW = $clog2(LOG_LEVELS + 1);
    localparam int GW = $clog2(PW);

    typedef enum logic [50:0] {
        S_IDLE     = 51'h1 << 0,
        Q_RD_ISSUE = 51'h1 << 1,
        Q_RD_DONE  = 51'h1 << 2,
        Q_L_A      = 51'h1 << 3,
        Q_L_B      = 51'h1 << 4,
        Q_L_C      = 51'h1 << 5,
        Q_L_D      = 51'h1 << 6,
        Q_L_E      = 51'h1 << 7,
        Q_L_F      = 51'h1 << 8,
        Q_L_G      = 51'h1 << 9,
        Q_L_H      = 51'h1 << 10,
        B_CC_CLR   = 51'h1 << 11,
        B_CC_T     = 51'h1 << 12,
        B_CC_C     = 51'h1 << 13,
        B_CC_W     = 51'h1 << 14,
        B_CX_RD    = 51'h1 << 15,
        B_CX_W     = 51'h1 << 16,
        B_R0_T     = 51'h1 << 17,
        B_R0_C     = 51'h1 << 18,
        B_R0_W     = 51'h1 << 19,
        B_K_A      = 51'h1 << 20,
        B_K_B      = 51'h1 << 21,
        B_K_C      = 51'h1 << 22,
        B_CLR      = 51'h1 << 23,
        B_CNT_K    = 51'h1 << 24,
        B_CNT_C    = 51'h1 << 25,
        B_CNT_W    = 51'h1 << 26,
        B_PS_RD    = 51'h1 << 27,
        B_PS_W     = 51'h1 << 28,
        B_D_K      = 51'h1 << 29,
        B_D_C      = 51'h1 << 30,
        B_D_W      = 51'h1 << 31,
        B_F_O      = 51'h1 << 32,
        B_F_K      = 51'h1 << 33,
        B_F_C      = 51'h1 << 34,
        B_F_W      = 51'h1 << 35,
        B_RR_S     = 51'h1 << 36,
        B_RR_K     = 51'h1 << 37,
        B_RR_W     = 51'h1 << 38,
        B_H_R      = 51'h1 << 39,
        B_H_S      = 51'h1 << 40,
        B_H_J      = 51'h1 << 41,
        B_H_CMP    = 51'h1 << 42,
        B_H_TA     = 51'h1 << 43,
        B_H_TB     = 51'h1 << 44,
        B_H_WR     = 51'h1 << 45,
        B_T0_R     = 51'h1 << 46,
        B_T0_W     = 51'h1 << 47,
        B_TL_A     = 51'h1 << 48,
        B_TL_B     = 51'h1 << 49,
        B_TL_C     = 51'h1 << 50
    } state_t;

    // control registers
    state_t            state_reg, state_next;
    logic [PW-1:0]     len_reg, len_next;
    logic              built_reg, built_next;
    logic [PW-1:0]     idx_reg, idx_next;
    logic [7:0]        chr_reg, chr_next;
    logic [PW:0]       step_reg, step_next;
    logic              pass_reg, pass_next;
    logic              first_reg, first_next;
    logic              sorted_reg, sorted_next;
    logic [LW-1:0]     lv_reg, lv_next;
    logic [GW-1:0]     top_reg, top_next;
    logic              done_reg, done_next;

    // datapath registers
    logic [PW-1:0]     acc_reg, acc_next;
    logic [PW-1:0]     c_reg, c_next;
    logic [PW-1:0]     pi_reg, pi_next;
    logic [PW-1:0]     j_reg, j_next;
    logic [PW-1:0]     k_reg, k_next;
    logic [PW-1:0]     r_reg, r_next;
    logic [7:0]        ta_reg, ta_next;
    logic [PW-1:0]     a_reg, a_next;
    logic [PW-1:0]     lfk_reg, lfk_next;
    logic [PW-1:0]     lsk_reg, lsk_next;
    logic [PW-1:0]     lrank_reg, lrank_next;
    logic [PW-1:0]     pa_reg, pa_next;
    logic [PW-1:0]     pb_reg, pb_next;
    logic [PW-1:0]     x_reg, x_next;
    logic [PW-1:0]     lo_reg, lo_next;
    logic [PW-1:0]     hi_reg, hi_next;
    logic [SW-1:0]     base_prev_reg, base_prev_next;
    logic [SW-1:0]     base_cur_reg, base_cur_next;
    logic [PW-1:0]     sa_value_reg, sa_value_next;
    logic [PW-1:0]     rank_value_reg, rank_value_next;
    logic [PW-1:0]     height_value_reg, height_value_next;
    logic [PW-1:0]     lcp_value_reg, lcp_value_next;
    logic [1:0]        status_reg, status_next;

    // memories
    logic [7:0]    text_mem [0:D-1];
    logic          text_we;
    logic [PW-1:0] text_wa, text_ra;
    logic [7:0]    text_wd, text_q_reg;

    logic [PW-1:0] ccnt_mem [0:255];
    logic          ccnt_we;
    logic [7:0]    ccnt_wa, ccnt_ra;
    logic [PW-1:0] ccnt_wd, ccnt_q_reg;

    logic [PW-1:0] rank_mem [0:D-1];
    logic          rank_we;
    logic [PW-1:0] rank_wa, rank_ra, rank_wd, rank_q_reg;

    logic [PW-1:0] fk_mem [0:D-1];
    logic          fk_we;
    logic [PW-1:0] fk_wa, fk_ra, fk_wd, fk_q_reg;

    logic [PW-1:0] sk_mem [0:D-1];
    logic          sk_we;
    logic [PW-1:0] sk_wa, sk_ra, sk_wd, sk_q_reg;

    logic [PW-1:0] obs_mem [0:D-1];
    logic          obs_we;
    logic [PW-1:0] obs_wa, obs_ra, obs_wd, obs_q_reg;

    logic [PW-1:0] cnt_mem [0:D-1];
    logic          cnt_we;
    logic [PW-1:0] cnt_wa, cnt_ra, cnt_wd, cnt_q_reg;

    logic [PW-1:0] sa_mem [0:D-1];
    logic          sa_we;
    logic [PW-1:0] sa_wa, sa_ra, sa_wd, sa_q_reg;

    logic [PW-1:0] hgt_mem [0:D-1];
    logic          hgt_we;
    logic [PW-1:0] hgt_wa, hgt_ra, hgt_wd, hgt_q_reg;

    logic [PW-1:0] st_mem [0:SD-1];
    logic          st_we;
    logic [SW-1:0] st_wa, st_ra;
    logic [PW-1:0] st_wd, st_q_reg;

    // helpers
    logic [PW-1:0] len_eff;
    logic [PW-1:0] ld_len;
    logic          bad_a, bad_b;
    logic [PW-1:0] key_q;
    logic [PW-1:0] span;
    logic [PW-1:0] lg_in;
    logic [GW-1:0] lg_res;
    logic [PW:0]   sum_ik, sum_jk;
    logic [PW+1:0] sec_pos;
    logic [PW:0]   half, up;
    logic [PW-1:0] o_pos;
    logic [PW-1:0] q_off;
    logic [PW-1:0] new_rank;
    logic          same_keys;
    logic [PW-1:0] min_ast;

    assign len_eff   = built_reg ? '0 : len_reg;
    assign ld_len    = len_eff + PW'(1);
    assign bad_a     = (pos_a == '0) || (pos_a > len_reg);
    assign bad_b     = (pos_b == '0) || (pos_b > len_reg);
    assign key_q     = pass_reg ? fk_q_reg : sk_q_reg;
    assign span      = hi_reg - lo_reg + PW'(1);
    assign lg_in     = (state_reg == Q_L_D) ? span : len_reg;
    assign sum_ik    = {1'b0, idx_reg} + {1'b0, k_reg};
    assign sum_jk    = {1'b0, j_reg} + {1'b0, k_reg};
    assign sec_pos   = (PW+2)'(idx_reg) + (PW+2)'(step_reg);
    assign half      = (PW+1)'(1) << (lv_reg - LW'(1));
    assign up        = (PW+1)'(idx_reg) + half;
    assign o_pos     = (up < (PW+1)'(len_reg)) ? PW'(up) : len_reg;
    assign q_off     = hi_reg + PW'(1) - (PW'(1) << lv_reg);
    assign same_keys = (fk_q_reg == lfk_reg) && (sk_q_reg == lsk_reg);
    assign new_rank  = first_reg ? PW'(1) : (same_keys ? lrank_reg : lrank_reg + PW'(1));
    assign min_ast   = (a_reg < st_q_reg) ? a_reg : st_q_reg;

    salcp_log2 #(.W(PW)) u_log2 (
        .value  (lg_in),
        .result (lg_res)
    );

    always_comb
    begin
        state_next        = state_reg;
        len_next          = len_reg;
        built_next        = built_reg;
        idx_next          = idx_reg;
        chr_next          = chr_reg;
        step_next         = step_reg;
        pass_next         = pass_reg;
        first_next        = first_reg;
        sorted_next       = sorted_reg;
        lv_next           = lv_reg;
        top_next          = top_reg;
        done_next         = 1'b0;
        acc_next          = acc_reg;
        c_next            = c_reg;
        pi_next           = pi_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        r_next            = r_reg;
        ta_next           = ta_reg;
        a_next            = a_reg;
        lfk_next          = lfk_reg;
        lsk_next          = lsk_reg;
        lrank_next        = lrank_reg;
        pa_next           = pa_reg;
        pb_next           = pb_reg;
        x_next            = x_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        base_prev_next    = base_prev_reg;
        base_cur_next     = base_cur_reg;
        sa_value_next     = sa_value_reg;
        rank_value_next   = rank_value_reg;
        height_value_next = height_value_reg;
        lcp_value_next    = lcp_value_reg;
        status_next       = status_reg;

        text_we = 1'b0; text_wa = '0; text_wd = '0; text_ra = '0;
        ccnt_we = 1'b0; ccnt_wa = '0; ccnt_wd = '0; ccnt_ra = '0;
        rank_we = 1'b0; rank_wa = '0; rank_wd = '0; rank_ra = '0;
        fk_we   = 1'b0; fk_wa   = '0; fk_wd   = '0; fk_ra   = '0;
        sk_we   = 1'b0; sk_wa   = '0; sk_wd   = '0; sk_ra   = '0;
        obs_we  = 1'b0; obs_wa  = '0; obs_wd  = '0; obs_ra  = '0;
        cnt_we  = 1'b0; cnt_wa  = '0; cnt_wd  = '0; cnt_ra  = '0;
        sa_we   = 1'b0; sa_wa   = '0; sa_wd   = '0; sa_ra   = '0;
        hgt_we  = 1'b0; hgt_wa  = '0; hgt_wd  = '0; hgt_ra  = '0;
        st_we   = 1'b0; st_wa   = '0; st_wd   = '0; st_ra   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sa_value_next     = '0;
                    rank_value_next   = '0;
                    height_value_next = '0;
                    lcp_value_next    = '0;
                    status_next       = ST_OK;
                    pa_next           = pos_a;
                    pb_next           = pos_b;
                    case (cmd)
                        CMD_LOAD:
                        begin
                            done_next  = 1'b1;
                            built_next = 1'b0;
                            len_next   = len_eff;
                            if (len_eff < PW'(MAX_LEN))
                            begin
                                len_next = ld_len;
                                text_we  = 1'b1;
                                text_wa  = ld_len;
                                text_wd  = char_in;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                            if (last_char)
                            begin
                                chr_next   = '0;
                                state_next = B_CC_CLR;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!built_reg)
                            begin
                                status_next = ST_UNBUILT;
                                done_next   = 1'b1;
                            end
                            else if (bad_a)
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = Q_RD_ISSUE;
                            end
                        end
                        CMD_LCP:
                        begin
                            if (!built_reg)
                            begin
                                status_next = ST_UNBUILT;
                                done_next   = 1'b1;
                            end
                            else if (bad_a || bad_b)
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (pos_a == pos_b)
                            begin
                                lcp_value_next = len_reg + PW'(1) - pos_a;
                                done_next      = 1'b1;
                            end
                            else
                            begin
                                state_next = Q_L_A;
                            end
                        end
                        default:
                        begin
                            status_next = ST_RANGE;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            Q_RD_ISSUE:
            begin
                sa_ra      = pa_reg;
                rank_ra    = pa_reg;
                hgt_ra     = pa_reg;
                state_next = Q_RD_DONE;
            end
            Q_RD_DONE:
            begin
                sa_value_next     = sa_q_reg;
                rank_value_next   = rank_q_reg;
                height_value_next = hgt_q_reg;
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end

            Q_L_A:
            begin
                rank_ra    = pa_reg;
                state_next = Q_L_B;
            end
            Q_L_B:
            begin
                x_next     = rank_q_reg;
                rank_ra    = pb_reg;
                state_next = Q_L_C;
            end
            Q_L_C:
            begin
                if (x_reg < rank_q_reg)
                begin
                    lo_next = x_reg + PW'(1);
                    hi_next = rank_q_reg;
                end
                else
                begin
                    lo_next = rank_q_reg + PW'(1);
                    hi_next = x_reg;
                end
                state_next = Q_L_D;
            end
            Q_L_D:
            begin
                if (int'(lg_res) > LOG_LEVELS - 1)
                begin
                    lv_next = LW'(LOG_LEVELS - 1);
                end
                else
                begin
                    lv_next = LW'(lg_res);
                end
                state_next = Q_L_E;
            end
            Q_L_E:
            begin
                base_prev_next = SW'(lv_reg * D);
                state_next     = Q_L_F;
            end
            Q_L_F:
            begin
                st_ra      = base_prev_reg + SW'(lo_reg);
                state_next = Q_L_G;
            end
            Q_L_G:
            begin
                a_next     = st_q_reg;
                st_ra      = base_prev_reg + SW'(q_off);
                state_next = Q_L_H;
            end
            Q_L_H:
            begin
                lcp_value_next = min_ast;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end

            // character histogram
            B_CC_CLR:
            begin
                ccnt_we = 1'b1;
                ccnt_wa = chr_reg;
                ccnt_wd = '0;
                chr_next = chr_reg + 8'd1;
                if (chr_reg == 8'hFF)
                begin
                    idx_next   = PW'(1);
                    state_next = B_CC_T;
                end
            end
            B_CC_T:
            begin
                text_ra    = idx_reg;
                state_next = B_CC_C;
            end
            B_CC_C:
            begin
                ccnt_ra    = text_q_reg;
                chr_next   = text_q_reg;
                state_next = B_CC_W;
            end
            B_CC_W:
            begin
                ccnt_we = 1'b1;
                ccnt_wa = chr_reg;
                ccnt_wd = ccnt_q_reg + PW'(1);
                idx_next = idx_reg + PW'(1);
                state_next = B_CC_T;
                if (idx_reg == len_reg)
                begin
                    chr_next   = '0;
                    acc_next   = '0;
                    state_next = B_CX_RD;
                end
            end
            // exclusive prefix: count of smaller characters
            B_CX_RD:
            begin
                ccnt_ra    = chr_reg;
                state_next = B_CX_W;
            end
            B_CX_W:
            begin
                ccnt_we  = 1'b1;
                ccnt_wa  = chr_reg;
                ccnt_wd  = acc_reg;
                acc_next = acc_reg + ccnt_q_reg;
                chr_next = chr_reg + 8'd1;
                state_next = B_CX_RD;
                if (chr_reg == 8'hFF)
                begin
                    idx_next   = PW'(1);
                    state_next = B_R0_T;
                end
            end
            B_R0_T:
            begin
                text_ra    = idx_reg;
                state_next = B_R0_C;
            end
            B_R0_C:
            begin
                ccnt_ra    = text_q_reg;
                state_next = B_R0_W;
            end
            B_R0_W:
            begin
                rank_we  = 1'b1;
                rank_wa  = idx_reg;
                rank_wd  = ccnt_q_reg + PW'(1);
                idx_next = idx_reg + PW'(1);
                state_next = B_R0_T;
                if (idx_reg == len_reg)
                begin
                    idx_next   = PW'(1);
                    step_next  = (PW+1)'(1);
                    state_next = B_K_A;
                end
            end

            // doubling round: keys
            B_K_A:
            begin
                rank_ra    = idx_reg;
                state_next = B_K_B;
            end
            B_K_B:
            begin
                fk_we = 1'b1;
                fk_wa = idx_reg;
                fk_wd = rank_q_reg;
                if (sec_pos <= (PW+2)'(len_reg))
                begin
                    rank_ra    = PW'(sec_pos);
                    state_next = B_K_C;
                end
                else
                begin
                    sk_we    = 1'b1;
                    sk_wa    = idx_reg;
                    sk_wd    = '0;
                    idx_next = idx_reg + PW'(1);
                    state_next = B_K_A;
                    if (idx_reg == len_reg)
                    begin
                        idx_next   = '0;
                        pass_next  = 1'b0;
                        state_next = B_CLR;
                    end
                end
            end
            B_K_C:
            begin
                sk_we    = 1'b1;
                sk_wa    = idx_reg;
                sk_wd    = rank_q_reg;
                idx_next = idx_reg + PW'(1);
                state_next = B_K_A;
                if (idx_reg == len_reg)
                begin
                    idx_next   = '0;
                    pass_next  = 1'b0;
                    state_next = B_CLR;
                end
            end

            // counting sort, pass 0 on second keys, pass 1 on first keys
            B_CLR:
            begin
                cnt_we   = 1'b1;
                cnt_wa   = idx_reg;
                cnt_wd   = '0;
                idx_next = idx_reg + PW'(1);
                if (idx_reg == len_reg)
                begin
                    idx_next   = PW'(1);
                    state_next = B_CNT_K;
                end
            end
            B_CNT_K:
            begin
                fk_ra      = idx_reg;
                sk_ra      = idx_reg;
                state_next = B_CNT_C;
            end
            B_CNT_C:
            begin
                cnt_ra     = key_q;
                c_next     = key_q;
                state_next = B_CNT_W;
            end
            B_CNT_W:
            begin
                cnt_we   = 1'b1;
                cnt_wa   = c_reg;
                cnt_wd   = cnt_q_reg + PW'(1);
                idx_next = idx_reg + PW'(1);
                state_next = B_CNT_K;
                if (idx_reg == len_reg)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = B_PS_RD;
                end
            end
            B_PS_RD:
            begin
                cnt_ra     = idx_reg;
                state_next = B_PS_W;
            end
            B_PS_W:
            begin
                cnt_we   = 1'b1;
                cnt_wa   = idx_reg;
                cnt_wd   = acc_reg + cnt_q_reg;
                acc_next = acc_reg + cnt_q_reg;
                idx_next = idx_reg + PW'(1);
                state_next = B_PS_RD;
                if (idx_reg == len_reg)
                begin
                    idx_next   = PW'(1);
                    state_next = pass_reg ? B_F_O : B_D_K;
                end
            end
            B_D_K:
            begin
                sk_ra      = idx_reg;
                state_next = B_D_C;
            end
            B_D_C:
            begin
                cnt_ra     = sk_q_reg;
                c_next     = sk_q_reg;
                state_next = B_D_W;
            end
            B_D_W:
            begin
                cnt_we   = 1'b1;
                cnt_wa   = c_reg;
                cnt_wd   = cnt_q_reg - PW'(1);
                obs_we   = 1'b1;
                obs_wa   = len_reg - cnt_q_reg + PW'(1);
                obs_wd   = idx_reg;
                idx_next = idx_reg + PW'(1);
                state_next = B_D_K;
                if (idx_reg == len_reg)
                begin
                    idx_next   = '0;
                    pass_next  = 1'b1;
                    state_next = B_CLR;
                end
            end
            B_F_O:
            begin
                obs_ra     = idx_reg;
                state_next = B_F_K;
            end
            B_F_K:
            begin
                pi_next    = obs_q_reg;
                fk_ra      = obs_q_reg;
                state_next = B_F_C;
            end
            B_F_C:
            begin
                cnt_ra     = fk_q_reg;
                c_next     = fk_q_reg;
                state_next = B_F_W;
            end
            B_F_W:
            begin
                sa_we    = 1'b1;
                sa_wa    = cnt_q_reg;
                sa_wd    = pi_reg;
                cnt_we   = 1'b1;
                cnt_wa   = c_reg;
                cnt_wd   = cnt_q_reg - PW'(1);
                idx_next = idx_reg + PW'(1);
                state_next = B_F_O;
                if (idx_reg == len_reg)
                begin
                    idx_next    = PW'(1);
                    first_next  = 1'b1;
                    sorted_next = 1'b1;
                    state_next  = B_RR_S;
                end
            end

            // re-rank in sorted order
            B_RR_S:
            begin
                sa_ra      = idx_reg;
                state_next = B_RR_K;
            end
            B_RR_K:
            begin
                pi_next    = sa_q_reg;
                fk_ra      = sa_q_reg;
                sk_ra      = sa_q_reg;
                state_next = B_RR_W;
            end
            B_RR_W:
            begin
                rank_we    = 1'b1;
                rank_wa    = pi_reg;
                rank_wd    = new_rank;
                lrank_next = new_rank;
                lfk_next   = fk_q_reg;
                lsk_next   = sk_q_reg;
                first_next = 1'b0;
                if (!first_reg && same_keys)
                begin
                    sorted_next = 1'b0;
                end
                idx_next   = idx_reg + PW'(1);
                state_next = B_RR_S;
                if (idx_reg == len_reg)
                begin
                    idx_next = PW'(1);
                    if (sorted_next || (((PW+2)'(step_reg) << 1) > (PW+2)'(len_reg)))
                    begin
                        k_next     = '0;
                        state_next = B_H_R;
                    end
                    else
                    begin
                        step_next  = step_reg << 1;
                        state_next = B_K_A;
                    end
                end
            end

            // heights in text order
            B_H_R:
            begin
                rank_ra    = idx_reg;
                state_next = B_H_S;
            end
            B_H_S:
            begin
                r_next = rank_q_reg;
                if (rank_q_reg == PW'(1))
                begin
                    k_next   = '0;
                    hgt_we   = 1'b1;
                    hgt_wa   = rank_q_reg;
                    hgt_wd   = '0;
                    idx_next = idx_reg + PW'(1);
                    state_next = B_H_R;
                    if (idx_reg == len_reg)
                    begin
                        idx_next   = PW'(1);
                        state_next = B_T0_R;
                    end
                end
                else
                begin
                    if (k_reg != '0)
                    begin
                        k_next = k_reg - PW'(1);
                    end
                    sa_ra      = rank_q_reg - PW'(1);
                    state_next = B_H_J;
                end
            end
            B_H_J:
            begin
                j_next     = sa_q_reg;
                state_next = B_H_CMP;
            end
            B_H_CMP:
            begin
                if ((sum_ik <= {1'b0, len_reg}) && (sum_jk <= {1'b0, len_reg}))
                begin
                    text_ra    = PW'(sum_ik);
                    state_next = B_H_TA;
                end
                else
                begin
                    state_next = B_H_WR;
                end
            end
            B_H_TA:
            begin
                ta_next    = text_q_reg;
                text_ra    = PW'(sum_jk);
                state_next = B_H_TB;
            end
            B_H_TB:
            begin
                if (text_q_reg == ta_reg)
                begin
                    k_next     = k_reg + PW'(1);
                    state_next = B_H_CMP;
                end
                else
                begin
                    state_next = B_H_WR;
                end
            end
            B_H_WR:
            begin
                hgt_we   = 1'b1;
                hgt_wa   = r_reg;
                hgt_wd   = k_reg;
                idx_next = idx_reg + PW'(1);
                state_next = B_H_R;
                if (idx_reg == len_reg)
                begin
                    idx_next   = PW'(1);
                    state_next = B_T0_R;
                end
            end

            // sparse min table
            B_T0_R:
            begin
                hgt_ra     = idx_reg;
                state_next = B_T0_W;
            end
            B_T0_W:
            begin
                st_we    = 1'b1;
                st_wa    = SW'(idx_reg);
                st_wd    = hgt_q_reg;
                idx_next = idx_reg + PW'(1);
                state_next = B_T0_R;
                if (idx_reg == len_reg)
                begin
                    top_next       = lg_res;
                    idx_next       = PW'(1);
                    lv_next        = LW'(1);
                    base_prev_next = '0;
                    base_cur_next  = SW'(D);
                    if (lg_res != '0)
                    begin
                        state_next = B_TL_A;
                    end
                    else
                    begin
                        built_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            B_TL_A:
            begin
                st_ra      = base_prev_reg + SW'(idx_reg);
                state_next = B_TL_B;
            end
            B_TL_B:
            begin
                a_next     = st_q_reg;
                st_ra      = base_prev_reg + SW'(o_pos);
                state_next = B_TL_C;
            end
            B_TL_C:
            begin
                st_we    = 1'b1;
                st_wa    = base_cur_reg + SW'(idx_reg);
                st_wd    = min_ast;
                idx_next = idx_reg + PW'(1);
                state_next = B_TL_A;
                if (idx_reg == len_reg)
                begin
                    idx_next       = PW'(1);
                    lv_next        = lv_reg + LW'(1);
                    base_prev_next = base_cur_reg;
                    base_cur_next  = base_cur_reg + SW'(D);
                    if (!((int'(lv_reg) + 1 <= int'(top_reg)) &&
                          (int'(lv_reg) + 1 < LOG_LEVELS)))
                    begin
                        built_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            built_reg  <= 1'b0;
            idx_reg    <= '0;
            chr_reg    <= '0;
            step_reg   <= '0;
            pass_reg   <= 1'b0;
            first_reg  <= 1'b0;
            sorted_reg <= 1'b0;
            lv_reg     <= '0;
            top_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            built_reg  <= built_next;
            idx_reg    <= idx_next;
            chr_reg    <= chr_next;
            step_reg   <= step_next;
            pass_reg   <= pass_next;
            first_reg  <= first_next;
            sorted_reg <= sorted_next;
            lv_reg     <= lv_next;
            top_reg    <= top_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        c_reg            <= c_next;
        pi_reg           <= pi_next;
        j_reg            <= j_next;
        k_reg            <= k_next;
        r_reg            <= r_next;
        ta_reg           <= ta_next;
        a_reg            <= a_next;
        lfk_reg          <= lfk_next;
        lsk_reg          <= lsk_next;
        lrank_reg        <= lrank_next;
        pa_reg           <= pa_next;
        pb_reg           <= pb_next;
        x_reg            <= x_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        base_prev_reg    <= base_prev_next;
        base_cur_reg     <= base_cur_next;
        sa_value_reg     <= sa_value_next;
        rank_value_reg   <= rank_value_next;
        height_value_reg <= height_value_next;
        lcp_value_reg    <= lcp_value_next;
        status_reg       <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[text_wa] <= text_wd;
        end
        text_q_reg <= text_mem[text_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ccnt_we)
        begin
            ccnt_mem[ccnt_wa] <= ccnt_wd;
        end
        ccnt_q_reg <= ccnt_mem[ccnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_q_reg <= rank_mem[rank_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fk_we)
        begin
            fk_mem[fk_wa] <= fk_wd;
        end
        fk_q_reg <= fk_mem[fk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            sk_mem[sk_wa] <= sk_wd;
        end
        sk_q_reg <= sk_mem[sk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (obs_we)
        begin
            obs_mem[obs_wa] <= obs_wd;
        end
        obs_q_reg <= obs_mem[obs_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_q_reg <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sa_we)
        begin
            sa_mem[sa_wa] <= sa_wd;
        end
        sa_q_reg <= sa_mem[sa_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hgt_we)
        begin
            hgt_mem[hgt_wa] <= hgt_wd;
        end
        hgt_q_reg <= hgt_mem[hgt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_wa] <= st_wd;
        end
        st_q_reg <= st_mem[st_ra];
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign sa_value     = sa_value_reg;
    assign rank_value   = rank_value_reg;
    assign height_value = height_value_reg;
    assign lcp_value    = lcp_value_reg;
    assign status       = status_reg;

    `SALCP_ASSERT(a_state_onehot, $onehot(state_reg), "state register not one-hot")
    `SALCP_ASSERT_IMP(a_text_wr_idle, text_we, state_reg == S_IDLE, "text written while busy")
    `SALCP_ASSERT_IMP(a_built_rise, $rose(built_reg), $past(state_reg == B_TL_C || state_reg == B_T0_W), "built set outside table build")
    `SALCP_ASSERT_IMP(a_lcp_bound, done && status == ST_OK, lcp_value <= len_reg, "lcp exceeds text length")

endmodule
